>>> hw/rtl/psl_pkg.sv
// Shared types, constants and helpers for the positional list store.
`default_nettype none

package psl_pkg;

  // List capacity and the widths that follow from it.
  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned LenW     = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 7;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmpW     = ((LenW > PosW) ? LenW : PosW) + 1;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindDelete = 2'd1,
    KindGet    = 2'd2,
    KindClear  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusBadPos = 2'd1,
    StatusFull   = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } in_req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  read_value;
    logic [PosW-1:0]          length;
  } out_rsp_t;

  // Access bundle from the sequencer to the entry memory.
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [DataW-1:0]  wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } ram_req_t;

  // Reports a list length in the 7-bit length field, masked as needed.
  function automatic logic [PosW-1:0] len_field(input logic [LenW-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[PosW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/psl_ram.sv
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none

module psl_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]                rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/psl_seq.sv
// Request sequencer: range checks, entry shifting through the memory, result build.
`default_nettype none

module psl_seq
  import psl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_stall_o,
  input  wire in_req_t          req_i,
  output logic                  res_valid_o,
  input  wire logic             res_take_i,
  output out_rsp_t              res_o,
  output ram_req_t              ram_o,
  input  wire logic [DataW-1:0] ram_rdata_i
);

  typedef enum logic [5:0] {
    SIdle    = 6'b000001,
    SShift   = 6'b000010,
    SDrain   = 6'b000100,
    STail    = 6'b001000,
    SGetData = 6'b010000,
    SResp    = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]  stop_q, stop_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              dir_ins_q, dir_ins_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_addr_q, pend_addr_d;
  logic [DataW-1:0]  val_q, val_d;
  out_rsp_t          res_q, res_d;

  logic [CmpW-1:0]   pos_c, cnt_c;
  logic              ins_pos_ok, rng_ok, is_full;
  logic [AddrW-1:0]  idx_c, last_c;

  // Position checks against the current length.
  always_comb begin
    pos_c      = CmpW'(req_i.position);
    cnt_c      = CmpW'(count_q);
    ins_pos_ok = (pos_c != '0) && (pos_c <= cnt_c + CmpW'(1));
    rng_ok     = (pos_c != '0) && (pos_c <= cnt_c);
    is_full    = (cnt_c >= CmpW'(Capacity));
    idx_c      = AddrW'(pos_c - CmpW'(1));
    last_c     = AddrW'(cnt_c - CmpW'(1));
  end

  assign req_stall_o = (state_q != SIdle);
  assign res_valid_o = (state_q == SResp);
  assign res_o       = res_q;

  // Next-state logic and memory access sequencing.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    stop_d      = stop_q;
    idx_d       = idx_q;
    dir_ins_d   = dir_ins_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    val_d       = val_q;
    res_d       = res_q;

    // A shifted entry read in the previous cycle is written back one slot over.
    ram_o.we    = pend_q;
    ram_o.waddr = pend_addr_q;
    ram_o.wdata = ram_rdata_i;
    ram_o.re    = 1'b0;
    ram_o.raddr = rd_ptr_q;

    case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          res_d.status     = StatusOk;
          res_d.read_value = '0;
          res_d.length     = len_field(count_q);
          state_d          = SResp;
          case (req_i.kind)
            KindInsert: begin
              if (!ins_pos_ok) begin
                res_d.status = StatusBadPos;
              end else if (is_full) begin
                res_d.status = StatusFull;
              end else begin
                count_d      = count_q + LenW'(1);
                res_d.length = len_field(count_q + LenW'(1));
                val_d        = req_i.value;
                idx_d        = idx_c;
                dir_ins_d    = 1'b1;
                if (pos_c == cnt_c + CmpW'(1)) begin
                  state_d = STail;
                end else begin
                  rd_ptr_d = last_c;
                  stop_d   = idx_c;
                  state_d  = SShift;
                end
              end
            end
            KindDelete: begin
              if (!rng_ok) begin
                res_d.status = StatusBadPos;
              end else begin
                count_d      = count_q - LenW'(1);
                res_d.length = len_field(count_q - LenW'(1));
                dir_ins_d    = 1'b0;
                if (pos_c != cnt_c) begin
                  rd_ptr_d = idx_c + AddrW'(1);
                  stop_d   = last_c;
                  state_d  = SShift;
                end
              end
            end
            KindGet: begin
              if (!rng_ok) begin
                res_d.status = StatusBadPos;
              end else begin
                ram_o.re    = 1'b1;
                ram_o.raddr = idx_c;
                state_d     = SGetData;
              end
            end
            default: begin
              count_d      = '0;
              res_d.length = '0;
            end
          endcase
        end
      end
      // One entry read per cycle; its write lands in the next cycle.
      SShift: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = rd_ptr_q;
        pend_d      = 1'b1;
        pend_addr_d = dir_ins_q ? (rd_ptr_q + AddrW'(1)) : (rd_ptr_q - AddrW'(1));
        if (rd_ptr_q == stop_q) begin
          state_d = SDrain;
        end else begin
          rd_ptr_d = dir_ins_q ? (rd_ptr_q - AddrW'(1)) : (rd_ptr_q + AddrW'(1));
        end
      end
      SDrain: begin
        state_d = dir_ins_q ? STail : SResp;
      end
      // The new value goes into the opened slot.
      STail: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = val_q;
        state_d     = SResp;
      end
      SGetData: begin
        res_d.read_value = ram_rdata_i;
        state_d          = SResp;
      end
      SResp: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rd_ptr_q    <= rd_ptr_d;
    stop_q      <= stop_d;
    idx_q       <= idx_d;
    dir_ins_q   <= dir_ins_d;
    pend_addr_q <= pend_addr_d;
    val_q       <= val_d;
    res_q       <= res_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_store.sv
// Positional list store: an ordered list of up to 64 signed 32-bit values.
// A request on in_i (kind, position, value) is taken when in_valid_i is high
// and in_stall_o is low. Kinds: insert at position 1..length+1, delete at
// 1..length, get at 1..length, and clear. Each request gives one result on
// out_o (status, read_value, length), offered while out_valid_o is high and
// taken when out_stall_i is low.
// Requests are served one at a time. The entries live in one memory with a
// registered read; insert and delete move the following entries one slot per
// cycle through that memory, and then insert writes the new value into the
// opened slot. Appending and deleting the last entry move no entries; get
// reads one entry; clear and rejected requests do not touch the memory.
// The next request is accepted only once the result has entered the output
// register.
// The output register holds a finished result while the receiver stalls; the
// block then takes and works on the next request, and holds that result
// internally until the output register frees up.
// Reset empties the list; the memory itself is not cleared.
`default_nettype none

module positional_list_store
  import psl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_req_t   in_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_rsp_t       out_o
);

  logic              res_valid;
  logic              res_take;
  out_rsp_t          res;
  ram_req_t          ram_req;
  logic [DataW-1:0]  ram_rdata;
  logic              out_valid_q;
  out_rsp_t          out_q;

  psl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  psl_ram #(
    .Depth (Capacity),
    .Width (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // The output register loads when it is empty or being drained.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
